// ----- hdl/rmsprop_weight_update_defines.svh -----
// assertion macros for the rtl, included by rmsprop_weight_update.sv
`ifndef RMSPROP_WEIGHT_UPDATE_DEFINES_SVH
`define RMSPROP_WEIGHT_UPDATE_DEFINES_SVH

// checked outside reset
`define RMSP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define RMSP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/rmsp_pkg.sv -----
`default_nettype none
package rmsp_pkg;

   localparam logic [15:0] DecayReset = 16'd64881;
   localparam logic [23:0] LearnReset = 24'd16777;
   localparam logic [28:0] EpsQ24     = 29'd1678;

   localparam logic [1:0] CsrDecayRate = 2'd0;
   localparam logic [1:0] CsrLearnRate = 2'd1;

   localparam int RootBits = 28;
   localparam int NumBits  = 56;

   typedef struct packed {
      logic [31:0]        nms;
      logic signed [31:0] w;
      logic [55:0]        prod;
      logic               gneg;
      logic               sat;
      logic               last;
   } side_type;

endpackage
`default_nettype wire

// ----- hdl/rmsp_sqrt.sv -----
`default_nettype none
module rmsp_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire rmsp_pkg::side_type         in_side,
   output logic                            out_valid,
   output logic [rmsp_pkg::RootBits-1:0]   out_root,
   output rmsp_pkg::side_type              out_side
);

   localparam int N = rmsp_pkg::RootBits;

   logic                valid_ff [1:N];
   logic [28:0]         rem_ff   [1:N];
   logic [N-1:0]        root_ff  [1:N];
   rmsp_pkg::side_type  side_ff  [1:N];

   // one result bit per stage, square root of nms * 2^24
   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam int I = N - 1 - k;
      logic               v_src;
      logic [28:0]        rem_src;
      logic [N-1:0]       root_src;
      rmsp_pkg::side_type side_src;
      logic [55:0]        x;
      logic [30:0]        cur;
      logic [30:0]        trial;
      logic               ge;
      logic [28:0]        rem_in;
      logic [N-1:0]       root_in;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = valid_ff[k];
         assign rem_src  = rem_ff[k];
         assign root_src = root_ff[k];
         assign side_src = side_ff[k];
      end

      always_comb begin
         x       = {side_src.nms, 24'd0};
         cur     = {rem_src, x[2*I+1 -: 2]};
         trial   = {1'b0, root_src, 2'b01};
         ge      = (cur >= trial);
         rem_in  = ge ? 29'(cur - trial) : cur[28:0];
         root_in = {root_src[N-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            side_ff[k+1] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_root  = root_ff[N];
   assign out_side  = side_ff[N];

endmodule
`default_nettype wire

// ----- hdl/rmsp_div.sv -----
`default_nettype none
module rmsp_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire logic [rmsp_pkg::RootBits-1:0] in_root,
   input  wire rmsp_pkg::side_type         in_side,
   output logic                            out_valid,
   output logic [rmsp_pkg::NumBits-1:0]    out_quot,
   output rmsp_pkg::side_type              out_side
);

   localparam int N = rmsp_pkg::NumBits;

   // entry stage: denominator and rounded numerator
   logic               ent_valid_ff;
   logic [28:0]        ent_den_ff;
   logic [N-1:0]       ent_num_ff;
   rmsp_pkg::side_type ent_side_ff;
   logic [28:0]        den_in;
   logic [N-1:0]       num_in;

   always_comb begin
      den_in = 29'(in_root) + rmsp_pkg::EpsQ24;
      num_in = in_side.prod + N'(den_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else if (en) begin
         ent_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ent_den_ff  <= den_in;
         ent_num_ff  <= num_in;
         ent_side_ff <= in_side;
      end
   end

   logic               valid_ff [1:N];
   logic [28:0]        rem_ff   [1:N];
   logic [28:0]        den_ff   [1:N];
   logic [N-1:0]       num_ff   [1:N];
   logic [N-1:0]       quot_ff  [1:N];
   rmsp_pkg::side_type side_ff  [1:N];

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam int I = N - 1 - k;
      logic               v_src;
      logic [28:0]        rem_src;
      logic [28:0]        den_src;
      logic [N-1:0]       num_src;
      logic [N-1:0]       quot_src;
      rmsp_pkg::side_type side_src;
      logic [29:0]        cur;
      logic               ge;
      logic [28:0]        rem_in;

      if (k == 0) begin : g_first
         assign v_src    = ent_valid_ff;
         assign rem_src  = '0;
         assign den_src  = ent_den_ff;
         assign num_src  = ent_num_ff;
         assign quot_src = '0;
         assign side_src = ent_side_ff;
      end else begin : g_next
         assign v_src    = valid_ff[k];
         assign rem_src  = rem_ff[k];
         assign den_src  = den_ff[k];
         assign num_src  = num_ff[k];
         assign quot_src = quot_ff[k];
         assign side_src = side_ff[k];
      end

      always_comb begin
         cur    = {rem_src, num_src[I]};
         ge     = (cur >= {1'b0, den_src});
         rem_in = ge ? 29'(cur - {1'b0, den_src}) : cur[28:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            den_ff[k+1]  <= den_src;
            num_ff[k+1]  <= num_src;
            quot_ff[k+1] <= {quot_src[N-2:0], ge};
            side_ff[k+1] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_quot  = quot_ff[N];
   assign out_side  = side_ff[N];

endmodule
`default_nettype wire

// ----- hdl/rmsprop_weight_update.sv -----
// throughput: one request per cycle; 5 front stages, a 28-stage square root
// and a 57-stage divider, one output register
// a stall at the response side holds every stage in place
// reset (synchronous) empties the pipeline and restores decay 64881, lr 16777
`default_nettype none
`include "rmsprop_weight_update_defines.svh"
module rmsprop_weight_update (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_grad,
   input  wire logic [31:0]        req_mean_square,
   input  wire logic signed [31:0] req_weight,
   input  wire logic               req_last_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [31:0]             rsp_new_mean_square,
   output logic signed [31:0]      rsp_new_weight,
   output logic                    rsp_saturated,
   output logic                    rsp_last_out
);

   logic        en;
   logic [15:0] decay_ff;
   logic [23:0] lr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= rmsp_pkg::DecayReset;
         lr_ff    <= rmsp_pkg::LearnReset;
      end else if (csr_wr_en) begin
         if (csr_index == rmsp_pkg::CsrDecayRate) begin
            decay_ff <= csr_wdata[15:0];
         end
         if (csr_index == rmsp_pkg::CsrLearnRate) begin
            lr_ff <= csr_wdata;
         end
      end
   end

   // whole pipe moves unless the output holds an untaken response
   assign en        = !(rsp_valid && !rsp_ready);
   assign req_ready = en;

   // s1: magnitude of gradient
   logic               s1_valid_ff;
   logic [31:0]        s1_gmag_ff;
   logic               s1_gneg_ff;
   logic [31:0]        s1_ms_ff;
   logic signed [31:0] s1_w_ff;
   logic               s1_last_ff;
   // s2: products
   logic               s2_valid_ff;
   logic [63:0]        s2_sqfull_ff;
   logic [55:0]        s2_prod_ff;
   logic [47:0]        s2_dm_ff;
   logic               s2_gneg_ff;
   logic signed [31:0] s2_w_ff;
   logic               s2_last_ff;
   // s3: rounded square
   logic               s3_valid_ff;
   logic [38:0]        s3_sq_ff;
   logic [55:0]        s3_prod_ff;
   logic [47:0]        s3_dm_ff;
   logic               s3_gneg_ff;
   logic signed [31:0] s3_w_ff;
   logic               s3_last_ff;
   // s4: weighted square
   logic               s4_valid_ff;
   logic [55:0]        s4_m2_ff;
   logic [55:0]        s4_prod_ff;
   logic [47:0]        s4_dm_ff;
   logic               s4_gneg_ff;
   logic signed [31:0] s4_w_ff;
   logic               s4_last_ff;
   // s5: new mean square
   logic               s5_valid_ff;
   rmsp_pkg::side_type s5_side_ff;

   logic [16:0]        wgt;
   logic [56:0]        acc;
   logic [40:0]        nms_full;
   rmsp_pkg::side_type s5_side_in;

   always_comb begin
      wgt      = 17'd65536 - {1'b0, decay_ff};
      acc      = 57'(s4_dm_ff) + 57'(s4_m2_ff) + 57'h8000;
      nms_full = acc[56:16];
      s5_side_in.sat  = |nms_full[40:32];
      s5_side_in.nms  = s5_side_in.sat ? 32'hFFFF_FFFF : nms_full[31:0];
      s5_side_in.w    = s4_w_ff;
      s5_side_in.prod = s4_prod_ff;
      s5_side_in.gneg = s4_gneg_ff;
      s5_side_in.last = s4_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_gmag_ff   <= req_grad[31] ? (~req_grad + 32'd1) : req_grad;
         s1_gneg_ff   <= req_grad[31];
         s1_ms_ff     <= req_mean_square;
         s1_w_ff      <= req_weight;
         s1_last_ff   <= req_last_in;

         s2_sqfull_ff <= 64'(s1_gmag_ff) * 64'(s1_gmag_ff);
         s2_prod_ff   <= 56'(lr_ff) * 56'(s1_gmag_ff);
         s2_dm_ff     <= 48'(decay_ff) * 48'(s1_ms_ff);
         s2_gneg_ff   <= s1_gneg_ff;
         s2_w_ff      <= s1_w_ff;
         s2_last_ff   <= s1_last_ff;

         s3_sq_ff     <= 39'((s2_sqfull_ff + 64'h80_0000) >> 24);
         s3_prod_ff   <= s2_prod_ff;
         s3_dm_ff     <= s2_dm_ff;
         s3_gneg_ff   <= s2_gneg_ff;
         s3_w_ff      <= s2_w_ff;
         s3_last_ff   <= s2_last_ff;

         s4_m2_ff     <= 56'(wgt) * 56'(s3_sq_ff);
         s4_prod_ff   <= s3_prod_ff;
         s4_dm_ff     <= s3_dm_ff;
         s4_gneg_ff   <= s3_gneg_ff;
         s4_w_ff      <= s3_w_ff;
         s4_last_ff   <= s3_last_ff;

         s5_side_ff   <= s5_side_in;
      end
   end

   logic                              sq_valid;
   logic [rmsp_pkg::RootBits-1:0]     sq_root;
   rmsp_pkg::side_type                sq_side;

   rmsp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_valid_ff),
      .in_side   (s5_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   logic                              dv_valid;
   logic [rmsp_pkg::NumBits-1:0]      dv_quot;
   rmsp_pkg::side_type                dv_side;

   rmsp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // apply signed step and clip to the q8.24 range
   logic signed [47:0] step;
   logic signed [47:0] nw;
   logic               w_ovf;
   logic signed [31:0] nw_sat;

   always_comb begin
      step   = dv_side.gneg ? -$signed({2'b00, dv_quot[45:0]})
                            :  $signed({2'b00, dv_quot[45:0]});
      nw     = 48'(dv_side.w) + step;
      w_ovf  = !((&nw[47:31]) || !(|nw[47:31]));
      if (!w_ovf) begin
         nw_sat = nw[31:0];
      end else if (nw[47]) begin
         nw_sat = 32'sh8000_0000;
      end else begin
         nw_sat = 32'sh7FFF_FFFF;
      end
   end

   logic               rsp_valid_ff;
   logic [31:0]        rsp_nms_ff;
   logic signed [31:0] rsp_nw_ff;
   logic               rsp_sat_ff;
   logic               rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_nms_ff  <= dv_side.nms;
         rsp_nw_ff   <= nw_sat;
         rsp_sat_ff  <= dv_side.sat || w_ovf;
         rsp_last_ff <= dv_side.last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_new_mean_square = rsp_nms_ff;
   assign rsp_new_weight      = rsp_nw_ff;
   assign rsp_saturated       = rsp_sat_ff;
   assign rsp_last_out        = rsp_last_ff;

   `RMSP_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "response valid after reset")
   `RMSP_ASSERT(a_sat_weight_clip, rsp_valid && rsp_saturated && rsp_new_mean_square != 32'hFFFF_FFFF |-> rsp_new_weight == 32'sh7FFF_FFFF || rsp_new_weight == 32'sh8000_0000, "saturated without clipped result")
   `RMSP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_mean_square) && $stable(rsp_new_weight), "response changed while stalled")

endmodule
`default_nettype wire
